// ===== rtl/lpf_pkg.sv =====
package lpf_pkg;

   localparam logic [5:0] POINTS_PER_BLOCK  = 6'd32;
   localparam logic [4:0] BLOCKS_PER_PACKET = 5'd12;

   localparam logic [15:0] HDR_UPPER    = 16'heeff;
   localparam logic [15:0] HDR_LOWER    = 16'hddff;
   localparam logic [7:0]  TRAILER_BYTE = 8'h1e;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

   // byte positions in the sequence one point can cause
   localparam logic [3:0] STEP_HDR_LO  = 4'd0;
   localparam logic [3:0] STEP_HDR_HI  = 4'd1;
   localparam logic [3:0] STEP_ROT_LO  = 4'd2;
   localparam logic [3:0] STEP_ROT_HI  = 4'd3;
   localparam logic [3:0] STEP_DIST_LO = 4'd4;
   localparam logic [3:0] STEP_DIST_HI = 4'd5;
   localparam logic [3:0] STEP_INTENS  = 4'd6;
   localparam logic [3:0] STEP_TR_LAST = 4'd12;

   typedef struct packed {
      logic        has_header;
      logic        hdr_lower;
      logic        has_trailer;
      logic [15:0] rotation;
      logic [15:0] distance;
      logic [7:0]  intensity;
   } lpf_cmd_type;

endpackage

// ===== rtl/lpf_front.sv =====
module lpf_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_wr_en,
   input  logic                 csr_wr_data,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic                 req_frame_start,
   input  logic [15:0]          req_rotation,
   input  logic [15:0]          req_distance,
   input  logic [7:0]           req_intensity,
   input  logic                 q_full,
   output logic                 q_push,
   output lpf_pkg::lpf_cmd_type q_cmd
);
   import lpf_pkg::*;

   logic       lasers_64_ff, lasers_64_in;
   logic [4:0] point_ff, point_in;
   logic [3:0] block_ff, block_in;
   logic [4:0] point_eff;
   logic [3:0] block_eff;
   logic [5:0] point_inc;
   logic [4:0] block_inc;
   logic       point_wrap, block_wrap;

   assign req_stall = q_full;
   assign q_push    = req_valid && !q_full;

   always_comb begin
      point_eff  = req_frame_start ? 5'd0 : point_ff;
      block_eff  = req_frame_start ? 4'd0 : block_ff;
      point_inc  = {1'b0, point_eff} + 6'd1;
      block_inc  = {1'b0, block_eff} + 5'd1;
      point_wrap = point_inc >= POINTS_PER_BLOCK;
      block_wrap = block_inc >= BLOCKS_PER_PACKET;

      q_cmd.has_header  = point_eff == 5'd0;
      q_cmd.hdr_lower   = lasers_64_ff && block_eff[0];
      q_cmd.has_trailer = point_wrap && block_wrap;
      q_cmd.rotation    = req_rotation;
      q_cmd.distance    = req_distance;
      q_cmd.intensity   = req_intensity;

      lasers_64_in = csr_wr_en ? csr_wr_data : lasers_64_ff;
      point_in     = point_ff;
      block_in     = block_ff;
      if (q_push) begin
         if (point_wrap) begin
            point_in = 5'd0;
            block_in = block_wrap ? 4'd0 : block_inc[3:0];
         end else begin
            point_in = point_inc[4:0];
            block_in = block_eff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lasers_64_ff <= 1'b1;
         point_ff     <= '0;
         block_ff     <= '0;
      end else begin
         lasers_64_ff <= lasers_64_in;
         point_ff     <= point_in;
         block_ff     <= block_in;
      end
   end

endmodule

// ===== rtl/lpf_queue.sv =====
module lpf_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  lpf_pkg::lpf_cmd_type push_cmd,
   output logic                 full,
   input  logic                 pop,
   output logic                 head_valid,
   output lpf_pkg::lpf_cmd_type head_cmd
);
   import lpf_pkg::*;

   lpf_cmd_type           entry_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_AW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_AW:0]     count_ff, count_in;
   logic                  do_push, do_pop;

   assign full       = count_ff == (QUEUE_AW+1)'(QUEUE_DEPTH);
   assign head_valid = count_ff != '0;
   assign head_cmd   = entry_ff[rd_ptr_ff];

   always_comb begin
      do_push   = push && !full;
      do_pop    = pop && head_valid;
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!do_push && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ===== rtl/lpf_back.sv =====
module lpf_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 q_valid,
   input  lpf_pkg::lpf_cmd_type q_cmd,
   output logic                 q_pop,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [7:0]           rsp_out_byte,
   output logic                 rsp_packet_end,
   output logic                 rsp_run_last
);
   import lpf_pkg::*;

   logic       active_ff, active_in;
   logic [3:0] step_ff, step_in;
   logic       valid_ff, valid_in;
   logic [7:0] byte_ff, byte_in;
   logic       end_ff, end_in;
   logic       last_ff, last_in;
   logic [3:0] cur_step, last_step;
   logic       emit;
   logic [7:0] hdr_hi;

   assign rsp_valid      = valid_ff;
   assign rsp_out_byte   = byte_ff;
   assign rsp_packet_end = end_ff;
   assign rsp_run_last   = last_ff;

   always_comb begin
      emit      = q_valid && (!valid_ff || !rsp_stall);
      cur_step  = active_ff ? step_ff : (q_cmd.has_header ? STEP_HDR_LO : STEP_DIST_LO);
      last_step = q_cmd.has_trailer ? STEP_TR_LAST : STEP_INTENS;
      hdr_hi    = q_cmd.hdr_lower ? HDR_LOWER[15:8] : HDR_UPPER[15:8];
      q_pop     = emit && (cur_step == last_step);

      case (cur_step)
         STEP_HDR_LO:  byte_in = HDR_UPPER[7:0];
         STEP_HDR_HI:  byte_in = hdr_hi;
         STEP_ROT_LO:  byte_in = q_cmd.rotation[7:0];
         STEP_ROT_HI:  byte_in = q_cmd.rotation[15:8];
         STEP_DIST_LO: byte_in = q_cmd.distance[7:0];
         STEP_DIST_HI: byte_in = q_cmd.distance[15:8];
         STEP_INTENS:  byte_in = q_cmd.intensity;
         default:      byte_in = TRAILER_BYTE;
      endcase

      end_in    = cur_step == STEP_TR_LAST;
      last_in   = cur_step == last_step;
      active_in = active_ff;
      step_in   = step_ff;
      valid_in  = valid_ff && rsp_stall;
      if (emit) begin
         valid_in  = 1'b1;
         active_in = !q_pop;
         step_in   = cur_step + 4'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         byte_ff <= byte_in;
         end_ff  <= end_in;
         last_ff <= last_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         step_ff   <= '0;
         valid_ff  <= 1'b0;
      end else begin
         active_ff <= active_in;
         step_ff   <= step_in;
         valid_ff  <= valid_in;
      end
   end

endmodule

// ===== rtl/lidar_packet_framer.sv =====
// Packs range-image points into data packet bytes, one byte per beat on the
// rsp_ side. A point costs 3 beats; the first point of a block adds 4 (block
// header and rotation) and the last point of a packet adds 6 trailer bytes, so
// the point rate is set by the byte-wide output sequencer. Points are
// classified on entry and held in a 4-deep queue, so req_ keeps flowing while a
// header or trailer drains, until the queue fills. Writing csr_wr_data selects
// 64-row mode (reset value 1); write it only when the block is idle.
module lidar_packet_framer (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic        csr_wr_data,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_frame_start,
   input  logic [15:0] req_rotation,
   input  logic [15:0] req_distance,
   input  logic [7:0]  req_intensity,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_packet_end,
   output logic        rsp_run_last
);
   import lpf_pkg::*;

   lpf_cmd_type push_cmd, head_cmd;
   logic        push, full, pop, head_valid;

   lpf_front u_front (
      .clock           (clock),
      .reset           (reset),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_frame_start (req_frame_start),
      .req_rotation    (req_rotation),
      .req_distance    (req_distance),
      .req_intensity   (req_intensity),
      .q_full          (full),
      .q_push          (push),
      .q_cmd           (push_cmd)
   );

   lpf_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_cmd   (push_cmd),
      .full       (full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_cmd   (head_cmd)
   );

   lpf_back u_back (
      .clock          (clock),
      .reset          (reset),
      .q_valid        (head_valid),
      .q_cmd          (head_cmd),
      .q_pop          (pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_packet_end (rsp_packet_end),
      .rsp_run_last   (rsp_run_last)
   );

endmodule
